// ----- sv/lfu_cache_table_unit_assert.svh -----
// assertion macros shared by the cache table block
`ifndef LFU_CACHE_TABLE_UNIT_ASSERT_SVH
`define LFU_CACHE_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk with arst_n as reset
`define LFU_ASSERT_IMP(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error("lfu assertion failed");

// next-cycle implication
`define LFU_ASSERT_NEXT(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) \
		else $error("lfu assertion failed");

`endif

// ----- sv/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Sizes, types and codes of the least-frequently-used cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W      = $clog2(ENTRIES + 1);
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int CAP_W      = 5;
	localparam int CMP_W      = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [VAL_W-1:0] READ_MISS = {VAL_W{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [COUNT_BITS-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_TOUCH,
		CMD_REPLACE
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} state_t;

	// broadcast to every cell
	typedef struct packed {
		op_t              op;
		idx_t             tgt;
		idx_t             tgt_rank;
		logic             set_value;
		logic [VAL_W-1:0] value;
		logic [KEY_W-1:0] key;
		logic             evict;
		idx_t             vic;
		idx_t             vic_rank;
	} cmd_t;

	// token handed from cell to cell during the scan
	typedef struct packed {
		logic             hit;
		idx_t             hit_idx;
		idx_t             hit_rank;
		logic [VAL_W-1:0] hit_val;
		logic             vic_found;
		idx_t             vic_idx;
		cnt_t             vic_cnt;
		idx_t             vic_rank;
		logic             free_found;
		idx_t             free_idx;
	} tok_t;

endpackage

// ----- sv/lfu_req_if.sv -----
// ----------------------------------------------------------------------------
// lfu_req_if
// Request channel: one get or put item.
// ----------------------------------------------------------------------------
interface lfu_req_if;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [31:0]       key;
	logic signed [31:0] value;

	modport source (output valid, mode, key, value, input ready);
	modport sink (input valid, mode, key, value, output ready);
endinterface

// ----- sv/lfu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lfu_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] read_value;

	modport source (output valid, hit, read_value, input ready);
	modport sink (input valid, hit, read_value, output ready);
endinterface

// ----- sv/lfu_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lfu_cfg_if
// Configuration write channel for the capacity register.
// ----------------------------------------------------------------------------
interface lfu_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- sv/lfu_cell.sv -----
// ----------------------------------------------------------------------------
// lfu_cell
// One cache entry: folds itself into the scan token and applies updates.
// ----------------------------------------------------------------------------
module lfu_cell import lfu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  idx_t cell_idx,
	input  cmd_t cmd,
	input  tok_t tok_in,
	output tok_t tok_out,
	output logic valid
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	cnt_t             cnt_q;
	idx_t             rank_q;
	tok_t             tok_d;
	tok_t             tok_q;

	always_comb begin
		tok_d = tok_in;
		if (!tok_in.hit && valid_q && key_q == cmd.key) begin
			tok_d.hit      = 1'b1;
			tok_d.hit_idx  = cell_idx;
			tok_d.hit_rank = rank_q;
			tok_d.hit_val  = value_q;
		end
		// lower count wins, ties go to the older entry
		if (valid_q && (!tok_in.vic_found || cnt_q < tok_in.vic_cnt ||
				(cnt_q == tok_in.vic_cnt && rank_q > tok_in.vic_rank))) begin
			tok_d.vic_found = 1'b1;
			tok_d.vic_idx   = cell_idx;
			tok_d.vic_cnt   = cnt_q;
			tok_d.vic_rank  = rank_q;
		end
		if (!tok_in.free_found && !valid_q) begin
			tok_d.free_found = 1'b1;
			tok_d.free_idx   = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			tok_q <= tok_d;
			unique case (cmd.op)
				CMD_TOUCH: begin
					if (cell_idx == cmd.tgt) begin
						rank_q <= '0;
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + COUNT_ONE;
						end
						if (cmd.set_value) begin
							value_q <= cmd.value;
						end
					end else if (valid_q && rank_q < cmd.tgt_rank) begin
						rank_q <= rank_q + IDX_W'(1);
					end
				end
				CMD_REPLACE: begin
					if (cell_idx == cmd.tgt) begin
						valid_q <= 1'b1;
						key_q   <= cmd.key;
						value_q <= cmd.value;
						cnt_q   <= COUNT_ONE;
						rank_q  <= '0;
					end else if (cmd.evict && cell_idx == cmd.vic) begin
						valid_q <= 1'b0;
					end else if (valid_q) begin
						if (cmd.evict && rank_q > cmd.vic_rank) begin
							rank_q <= rank_q;
						end else begin
							rank_q <= rank_q + IDX_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign tok_out = tok_q;
	assign valid   = valid_q;

endmodule

// ----- sv/lfu_cache_table_unit.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_table_unit: one request item at a time; after a request is taken the
// token walks the cell row in the scan state, then the update state registers the
// response; a waiting response holds the update and the next request.
// Reset clears valid bits and occupancy and sets capacity to 16; no clear pass.
// ----------------------------------------------------------------------------
module lfu_cache_table_unit import lfu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lfu_cfg_if.sink   cfg,
	lfu_req_if.sink   req,
	lfu_rsp_if.source rsp
);

	`include "lfu_cache_table_unit_assert.svh"

	state_t           state_q;
	state_t           state_d;
	idx_t             scan_q;
	logic [CAP_W-1:0] cap_q;
	logic [OCC_W-1:0] occ_q;
	logic             mode_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             rsp_valid_q;
	logic             rsp_hit_q;
	logic [VAL_W-1:0] rsp_val_q;

	cmd_t             cmd;
	tok_t             tok [ENTRIES];
	logic [ENTRIES-1:0] valid_bits;
	tok_t             res;
	logic             go;
	logic             res_hit;
	logic [VAL_W-1:0] res_val;
	logic             occ_inc;
	logic [CMP_W-1:0] eff_cap;
	logic             need_evict;

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			lfu_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cell_idx(IDX_W'(gi)),
				.cmd     (cmd),
				.tok_in  ((gi == 0) ? tok_t'('0) : tok[(gi == 0) ? 0 : gi - 1]),
				.tok_out (tok[gi]),
				.valid   (valid_bits[gi])
			);
		end
	endgenerate

	assign res = tok[ENTRIES-1];
	assign go  = (state_q == S_UPDATE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
	end
	assign need_evict = CMP_W'(occ_q) >= eff_cap;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (req.valid) state_d = S_SCAN;
			S_SCAN:   if (scan_q == IDX_W'(ENTRIES - 1)) state_d = S_UPDATE;
			S_UPDATE: if (go) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs and cell commands
	always_comb begin
		cmd           = '0;
		cmd.op        = CMD_NONE;
		cmd.key       = key_q;
		cmd.value     = value_q;
		cmd.vic       = res.vic_idx;
		cmd.vic_rank  = res.vic_rank;
		res_hit       = res.hit;
		res_val       = '0;
		occ_inc       = 1'b0;
		if (go) begin
			if (res.hit) begin
				cmd.op        = CMD_TOUCH;
				cmd.tgt       = res.hit_idx;
				cmd.tgt_rank  = res.hit_rank;
				cmd.set_value = (mode_q == MODE_PUT);
				res_val       = (mode_q == MODE_PUT) ? '0 : res.hit_val;
			end else if (mode_q == MODE_GET) begin
				res_val = READ_MISS;
			end else begin
				cmd.op    = CMD_REPLACE;
				cmd.evict = need_evict;
				occ_inc   = !need_evict;
				// first free slot once the victim is gone
				if (!need_evict) begin
					cmd.tgt = res.free_idx;
				end else if (res.free_found && res.free_idx < res.vic_idx) begin
					cmd.tgt = res.free_idx;
				end else begin
					cmd.tgt = res.vic_idx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			cap_q       <= CAP_RESET;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
			end else begin
				scan_q <= '0;
			end
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (occ_inc) begin
				occ_q <= occ_q + OCC_W'(1);
			end
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q  <= req.mode;
			key_q   <= req.key;
			value_q <= req.value;
		end
		if (go) begin
			rsp_hit_q <= res_hit;
			rsp_val_q <= res_val;
		end
	end

	assign cfg.ready      = 1'b1;
	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.read_value = rsp_val_q;

	`LFU_ASSERT_IMP(a_occ_matches_valid, 1'b1, $countones(valid_bits) == int'(occ_q))
	`LFU_ASSERT_NEXT(a_accept_starts_scan, req.valid && req.ready, state_q == S_SCAN)
	`LFU_ASSERT_NEXT(a_update_gives_rsp, go, rsp.valid && state_q == S_IDLE)
	`LFU_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= OCC_W'(ENTRIES))

endmodule
